FILE: rtl/cba_pkg.sv
package cba_pkg;

    // request codes
    typedef enum logic [1:0] {
        FN_ALLOC     = 2'd0,
        FN_MARK_USED = 2'd1,
        FN_MARK_FREE = 2'd2,
        FN_RESIZE    = 2'd3
    } func_t;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned FIELD_W  = 7;
    localparam int unsigned REQ_W    = FUNC_W + 3 * FIELD_W;
    localparam int unsigned RES_W    = 2 + FIELD_W;
    localparam int unsigned S_DATA_W = ((REQ_W + 7) / 8) * 8;
    localparam int unsigned M_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

FILE: rtl/cba_ram.sv
module cba_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/contiguous_block_allocator.sv
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: func, start_req, size, target_size
// m_      | out | m_tvalid/m_tready  | m_tdata: ok, run_start, moved
//
// one request at a time; a no-op or a request that fails its bounds goes straight to the
// result state, the longest runs a first-fit scan, an old-run release and a new-run mark
// the used bitmap sits in one single-bit ram: a scan reads one block per cycle,
// a mark sweep writes one block per cycle, so size and scan length set the run time
// after reset a clearing pass over the bitmap holds s_tready low
// a finished result waits in the output register while the next request is taken;
// the block stalls in its result state only if that register is still full
module contiguous_block_allocator
    import cba_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // func[1:0], start_req[8:2], size[15:9],
                                           // target_size[22:16], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // ok[0], run_start[7:1], moved[8], zero pad
);

    localparam int unsigned AW  = $clog2(NUM_BLOCKS);
    // pointer width: holds NUM_BLOCKS itself and sums of two 7-bit fields
    localparam int unsigned CW  = ((AW > FIELD_W) ? AW : FIELD_W) + 2;
    localparam logic [CW-1:0] NB_W  = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] NB_M1 = CW'(NUM_BLOCKS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,     // reset pass over the bitmap
        S_IDLE,
        S_CHECK,     // are the blocks after a run all free
        S_FIT,       // first-fit scan
        S_FREE_OLD,  // release the old run of a moved resize
        S_SET,       // write sweep over [ptr, lim)
        S_DONE
    } state_t;

    // request fields
    logic [FUNC_W-1:0]  in_func;
    logic [FIELD_W-1:0] in_start;
    logic [FIELD_W-1:0] in_size;
    logic [FIELD_W-1:0] in_target_size;
    logic [CW-1:0]      st_w, sz_w, nsz_w;

    assign in_func        = s_tdata[FUNC_W-1:0];
    assign in_start       = s_tdata[FUNC_W +: FIELD_W];
    assign in_size        = s_tdata[FUNC_W + FIELD_W +: FIELD_W];
    assign in_target_size = s_tdata[FUNC_W + 2 * FIELD_W +: FIELD_W];
    assign st_w  = CW'(in_start);
    assign sz_w  = CW'(in_size);
    assign nsz_w = CW'(in_target_size);

    state_t         state_reg;
    func_t          func_reg;
    logic [CW-1:0]  st_reg, sz_reg, nsz_reg;
    logic [CW-1:0]  ptr_reg;      // next block to read or write
    logic [CW-1:0]  lim_reg;      // end of the current range, exclusive
    logic [CW-1:0]  need_reg;     // run length wanted by a scan
    logic [CW-1:0]  run_reg;      // free blocks seen in a row
    logic [CW-1:0]  cand_reg;     // start of the run being counted
    logic           wval_reg;
    logic           dv_reg;       // read data arrives this cycle
    logic [CW-1:0]  daddr_reg;    // block that the arriving data belongs to
    logic                res_ok_reg, res_moved_reg;
    logic [FIELD_W-1:0]  res_start_reg;
    logic                m_valid_reg, m_ok_reg, m_moved_reg;
    logic [FIELD_W-1:0]  m_start_reg;

    // ram ports
    logic       scan, rd_issue, wr_en, used_bit, eval, hit, miss, scan_end, dv_next;
    logic [0:0] rd_data;
    logic [CW-1:0] run_inc;

    assign scan     = (state_reg == S_CHECK) || (state_reg == S_FIT);
    assign rd_issue = scan && (ptr_reg < lim_reg);
    assign wr_en    = ((state_reg == S_CLEAR) || (state_reg == S_SET) ||
                       (state_reg == S_FREE_OLD)) && (ptr_reg < lim_reg);

    cba_ram #(
        .WIDTH (1),
        .DEPTH (NUM_BLOCKS)
    ) u_map (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg[AW-1:0]),
        .wr_data (wval_reg),
        .rd_en   (rd_issue),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // block 0 is reserved and always reads as used
    assign used_bit = rd_data[0] || (daddr_reg == '0);
    assign eval     = scan && dv_reg;
    assign run_inc  = run_reg + CW'(1);
    assign hit      = eval && !used_bit && (run_inc == need_reg);
    // a check fails on the first used block, a fit fails past the last candidate
    assign miss     = eval && !hit &&
                      ((used_bit && (state_reg == S_CHECK)) ||
                       (daddr_reg == lim_reg - CW'(1)));
    assign scan_end = hit || miss;
    // drop a read in flight once the scan has decided
    assign dv_next  = rd_issue && !scan_end;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, m_moved_reg, m_start_reg, m_ok_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            ptr_reg     <= '0;
            lim_reg     <= NB_W;
            wval_reg    <= 1'b0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            dv_reg    <= dv_next;
            daddr_reg <= ptr_reg;
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (ptr_reg < lim_reg) begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        func_reg      <= func_t'(in_func);
                        st_reg        <= st_w;
                        sz_reg        <= sz_w;
                        nsz_reg       <= nsz_w;
                        res_ok_reg    <= 1'b0;
                        res_start_reg <= '0;
                        res_moved_reg <= 1'b0;
                        state_reg     <= S_DONE;
                        unique case (func_t'(in_func)) inside
                            FN_ALLOC: begin
                                if (sz_w == '0) begin
                                    res_ok_reg <= 1'b1;
                                end else if (sz_w <= NB_M1) begin
                                    ptr_reg   <= CW'(1);
                                    lim_reg   <= NB_W;
                                    need_reg  <= sz_w;
                                    run_reg   <= '0;
                                    cand_reg  <= CW'(1);
                                    state_reg <= S_FIT;
                                end
                            end
                            FN_MARK_USED, FN_MARK_FREE: begin
                                if (st_w + sz_w <= NB_W) begin
                                    ptr_reg       <= st_w;
                                    lim_reg       <= st_w + sz_w;
                                    wval_reg      <= (func_t'(in_func) == FN_MARK_USED);
                                    res_ok_reg    <= 1'b1;
                                    res_start_reg <= in_start;
                                    state_reg     <= S_SET;
                                end
                            end
                            FN_RESIZE: begin
                                if (st_w + sz_w <= NB_W) begin
                                    if (nsz_w > sz_w) begin
                                        if (st_w + nsz_w <= NB_W) begin
                                            ptr_reg   <= st_w + sz_w;
                                            lim_reg   <= st_w + nsz_w;
                                            need_reg  <= nsz_w - sz_w;
                                            run_reg   <= '0;
                                            cand_reg  <= st_w + sz_w;
                                            state_reg <= S_CHECK;
                                        end else if (nsz_w <= NB_M1) begin
                                            // cannot grow past the end: relocate
                                            ptr_reg   <= CW'(1);
                                            lim_reg   <= NB_W;
                                            need_reg  <= nsz_w;
                                            run_reg   <= '0;
                                            cand_reg  <= CW'(1);
                                            state_reg <= S_FIT;
                                        end
                                    end else begin
                                        // shrink: free the tail, possibly empty
                                        ptr_reg       <= st_w + nsz_w;
                                        lim_reg       <= st_w + sz_w;
                                        wval_reg      <= 1'b0;
                                        res_ok_reg    <= 1'b1;
                                        res_start_reg <= in_start;
                                        state_reg     <= S_SET;
                                    end
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (rd_issue) begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                    if (hit) begin
                        ptr_reg       <= st_reg + sz_reg;
                        lim_reg       <= st_reg + nsz_reg;
                        wval_reg      <= 1'b1;
                        res_ok_reg    <= 1'b1;
                        res_start_reg <= st_reg[FIELD_W-1:0];
                        state_reg     <= S_SET;
                    end else if (miss) begin
                        if (nsz_reg > NB_M1) begin
                            state_reg <= S_DONE;
                        end else begin
                            ptr_reg   <= CW'(1);
                            lim_reg   <= NB_W;
                            need_reg  <= nsz_reg;
                            run_reg   <= '0;
                            cand_reg  <= CW'(1);
                            state_reg <= S_FIT;
                        end
                    end else if (eval) begin
                        run_reg <= run_inc;
                    end
                end
                S_FIT: begin
                    if (rd_issue) begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end
                    if (hit) begin
                        res_ok_reg    <= 1'b1;
                        res_start_reg <= cand_reg[FIELD_W-1:0];
                        if (func_reg == FN_ALLOC) begin
                            ptr_reg   <= cand_reg;
                            lim_reg   <= cand_reg + need_reg;
                            wval_reg  <= 1'b1;
                            state_reg <= S_SET;
                        end else begin
                            // old run is released first, new run marked after
                            ptr_reg       <= st_reg;
                            lim_reg       <= st_reg + sz_reg;
                            wval_reg      <= 1'b0;
                            res_moved_reg <= (cand_reg != st_reg);
                            state_reg     <= S_FREE_OLD;
                        end
                    end else if (miss) begin
                        state_reg <= S_DONE;
                    end else if (eval) begin
                        if (used_bit) begin
                            run_reg  <= '0;
                            cand_reg <= daddr_reg + CW'(1);
                        end else begin
                            run_reg <= run_inc;
                        end
                    end
                end
                S_FREE_OLD: begin
                    if (ptr_reg < lim_reg) begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end else begin
                        ptr_reg   <= cand_reg;
                        lim_reg   <= cand_reg + nsz_reg;
                        wval_reg  <= 1'b1;
                        state_reg <= S_SET;
                    end
                end
                S_SET: begin
                    if (ptr_reg < lim_reg) begin
                        ptr_reg <= ptr_reg + CW'(1);
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_ok_reg    <= res_ok_reg;
                        m_start_reg <= res_start_reg;
                        m_moved_reg <= res_moved_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // the bitmap is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_issue && wr_en))
        else $error("bitmap read and write overlap");

    // sweeps stay inside the bitmap
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (ptr_reg < NB_W))
        else $error("bitmap write out of range");

    // a scan decides once
    a_hit_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        !(hit && miss))
        else $error("scan hit and miss together");

    // a result is only loaded from the result state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside result state");

    // a failed request reports no start and no move
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |-> ((m_start_reg == '0) && !m_moved_reg))
        else $error("failed request with nonzero payload");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cba_pkg::*;

    localparam int BLOCKS       = 128;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int SETTLE       = 2 * BLOCKS + 40;

    // same layout as the stream payloads, lowest field last
    typedef struct packed {
        logic [FIELD_W-1:0] target_size;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] start_req;
        func_t              func;
    } request_t;

    typedef struct packed {
        logic               moved;
        logic [FIELD_W-1:0] run_start;
        logic               ok;
    } outcome_t;

    // mirrors the used-block bitmap and queues the outcome of each request
    class bitmap_scoreboard;
        bit [BLOCKS-1:0] block_used;
        outcome_t        outcomes_due[$];
        int              per_func[4];
        int              n_failed;
        int              n_moved;
        int              results_seen;
        int              errors;

        function new();
            block_used    = '0;
            block_used[0] = 1'b1;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function bit span_free(int s, int n);
            if (s + n > BLOCKS) return 1'b0;
            for (int i = 0; i < n; i++)
                if (block_used[s + i]) return 1'b0;
            return 1'b1;
        endfunction

        function void fill_span(int s, int n, bit v);
            for (int i = 0; i < n; i++)
                if (s + i < BLOCKS) block_used[s + i] = v;
            block_used[0] = 1'b1;  // reserved block never frees
        endfunction

        // lowest start from block 1 with n free blocks, 0 when none
        function int first_fit(int n);
            if (n == 0 || n > BLOCKS - 1) return 0;
            for (int s = 1; s + n <= BLOCKS; s++)
                if (span_free(s, n)) return s;
            return 0;
        endfunction

        function outcome_t take_request(request_t req);
            outcome_t r;
            int       st;
            int       sz;
            int       nsz;
            int       s;
            r   = '0;
            st  = req.start_req;
            sz  = req.size;
            nsz = req.target_size;
            per_func[req.func]++;
            case (req.func) inside
                FN_ALLOC: begin
                    if (sz == 0) begin
                        r.ok = 1'b1;
                    end else begin
                        s = first_fit(sz);
                        if (s != 0) begin
                            fill_span(s, sz, 1'b1);
                            r.ok        = 1'b1;
                            r.run_start = FIELD_W'(s);
                        end
                    end
                end
                FN_MARK_USED, FN_MARK_FREE: begin
                    if (st + sz <= BLOCKS) begin
                        fill_span(st, sz, req.func == FN_MARK_USED);
                        r.ok        = 1'b1;
                        r.run_start = FIELD_W'(st);
                    end
                end
                default: begin
                    if (st + sz <= BLOCKS) begin
                        if (nsz > sz) begin
                            if (span_free(st + sz, nsz - sz)) begin
                                fill_span(st + sz, nsz - sz, 1'b1);
                                r.ok        = 1'b1;
                                r.run_start = FIELD_W'(st);
                            end else begin
                                // new run is searched while the old one is still held
                                s = first_fit(nsz);
                                if (s != 0) begin
                                    fill_span(st, sz, 1'b0);
                                    fill_span(s, nsz, 1'b1);
                                    r.ok        = 1'b1;
                                    r.run_start = FIELD_W'(s);
                                    r.moved     = (s != st);
                                end
                            end
                        end else begin
                            fill_span(st + nsz, sz - nsz, 1'b0);
                            r.ok        = 1'b1;
                            r.run_start = FIELD_W'(st);
                        end
                    end
                end
            endcase
            if (!r.ok) n_failed++;
            if (r.moved) n_moved++;
            outcomes_due.push_back(r);
            return r;
        endfunction

        function void field_check(string field, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            outcome_t got;
            outcome_t want;
            got = data[RES_W-1:0];
            results_seen++;
            if (outcomes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual ok=%0d start=%0d moved=%0d",
                         $time, got.ok, got.run_start, got.moved);
                return;
            end
            want = outcomes_due.pop_front();
            field_check("ok", want.ok, got.ok);
            field_check("run_start", want.run_start, got.run_start);
            field_check("moved", want.moved, got.moved);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // func, start_req, size, target_size, zero pad
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // ok, run_start, moved, zero pad

    bitmap_scoreboard sb = new;

    int live_start[$];
    int live_size[$];
    int burst_left;
    int idle_cycles;

    contiguous_block_allocator #(
        .NUM_BLOCKS(BLOCKS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic request_t make_req(func_t fn, int st, int sz, int nsz);
        request_t req;
        req.func        = fn;
        req.start_req   = FIELD_W'(st);
        req.size        = FIELD_W'(sz);
        req.target_size = FIELD_W'(nsz);
        return req;
    endfunction

    // offers one request in bursts with random gaps, then keeps track of live runs
    task automatic send_request(input request_t req, input int run_idx);
        outcome_t r;
        int       gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tdata  <= S_DATA_W'(req);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = sb.take_request(req);
        case (req.func)
            FN_ALLOC: begin
                if (r.ok && req.size != 0) begin
                    live_start.push_back(r.run_start);
                    live_size.push_back(req.size);
                end
            end
            FN_MARK_FREE: begin
                if (run_idx >= 0 && r.ok) begin
                    live_start.delete(run_idx);
                    live_size.delete(run_idx);
                end
            end
            FN_RESIZE: begin
                if (run_idx >= 0 && r.ok) begin
                    if (req.target_size == 0) begin
                        live_start.delete(run_idx);
                        live_size.delete(run_idx);
                    end else begin
                        live_start[run_idx] = r.run_start;
                        live_size[run_idx]  = req.target_size;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // frees every block but the reserved one and forgets the live runs
    task automatic clear_all();
        send_request(make_req(FN_MARK_FREE, 1, 127, 127), -1);
        live_start.delete();
        live_size.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // result side: checks transfers and stalls on its own pattern
    initial begin : result_side
        int mode;
        int mode_left;
        int hold_left;
        bit long_hold_done;
        mode           = 0;
        mode_left      = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) sb.check_result(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && sb.results_seen >= HOLD_AFTER) begin
                // long hold-off so the block fills up and backs up its input
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 1) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : request_side
        request_t req;
        int       pick;
        int       idx;
        int       sz;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        burst_left = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every request and the corner cases
        send_request(make_req(FN_ALLOC, 0, 0, 1), -1);        // zero-size alloc
        send_request(make_req(FN_ALLOC, 0, 127, 1), -1);      // largest alloc fills the map
        send_request(make_req(FN_ALLOC, 0, 1, 1), -1);        // no space
        send_request(make_req(FN_ALLOC, 0, 127, 1), -1);      // no space for the largest alloc
        send_request(make_req(FN_MARK_FREE, 0, 127, 1), -1);  // reserved block stays used
        send_request(make_req(FN_MARK_FREE, 127, 1, 1), -1);  // last block
        send_request(make_req(FN_MARK_USED, 127, 2, 1), -1);  // range past the end
        send_request(make_req(FN_MARK_USED, 127, 1, 1), -1);
        send_request(make_req(FN_MARK_USED, 5, 0, 1), -1);    // zero-size marks
        send_request(make_req(FN_MARK_FREE, 100, 0, 1), -1);
        send_request(make_req(FN_ALLOC, 0, 4, 1), -1);
        send_request(make_req(FN_RESIZE, 1, 4, 8), -1);       // grow in place
        send_request(make_req(FN_ALLOC, 0, 2, 1), -1);
        send_request(make_req(FN_RESIZE, 1, 8, 12), -1);      // blocked, relocates
        send_request(make_req(FN_RESIZE, 11, 12, 12), -1);    // same size
        send_request(make_req(FN_RESIZE, 11, 12, 5), -1);     // shrink frees the tail
        send_request(make_req(FN_RESIZE, 11, 5, 0), -1);      // resize to zero
        send_request(make_req(FN_RESIZE, 120, 8, 10), -1);    // grow past the end
        send_request(make_req(FN_RESIZE, 1, 127, 127), -1);
        send_request(make_req(FN_RESIZE, 127, 2, 3), -1);     // current run out of bounds
        send_request(make_req(FN_MARK_USED, 0, 127, 1), -1);
        send_request(make_req(FN_RESIZE, 1, 10, 20), -1);     // relocation with no space
        clear_all();
        send_request(make_req(FN_ALLOC, 0, 127, 127), -1);
        clear_all();

        // random: mostly well-formed alloc/free/resize on live runs, some noise
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) wait_drained();
            if (k % 100 == 99) begin
                clear_all();
                continue;
            end
            pick = $urandom_range(0, 99);
            idx  = -1;
            if (pick < 15) begin
                req = request_t'(REQ_W'($urandom));
            end else if (pick < 20) begin
                req = make_req(FN_MARK_USED, $urandom_range(0, 127), $urandom_range(1, 8),
                               $urandom_range(1, 127));
            end else if (live_start.size() == 0 || (pick < 55 && live_start.size() < 24)) begin
                case ($urandom_range(0, 19))
                    0:       sz = 0;
                    1:       sz = $urandom_range(32, 127);
                    default: sz = $urandom_range(1, 8);
                endcase
                req = make_req(FN_ALLOC, $urandom_range(0, 127), sz, $urandom_range(1, 127));
            end else if (pick < 75) begin
                idx = $urandom_range(0, live_start.size() - 1);
                req = make_req(FN_MARK_FREE, live_start[idx], live_size[idx],
                               $urandom_range(1, 127));
            end else begin
                idx = $urandom_range(0, live_start.size() - 1);
                sz  = live_size[idx];
                case ($urandom_range(0, 3))
                    0:       sz = $urandom_range(1, sz);
                    1:       sz = $urandom_range(1, 127);
                    default: sz = (sz + 6 > 127) ? 127 : $urandom_range(sz + 1, sz + 6);
                endcase
                req = make_req(FN_RESIZE, live_start[idx], live_size[idx], sz);
            end
            send_request(req, idx);
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("requests: %0d alloc, %0d mark used, %0d mark free, %0d resize",
                 sb.per_func[FN_ALLOC], sb.per_func[FN_MARK_USED],
                 sb.per_func[FN_MARK_FREE], sb.per_func[FN_RESIZE]);
        $display("results checked: %0d, refused: %0d, relocations: %0d, mismatches: %0d",
                 sb.results_seen, sb.n_failed, sb.n_moved, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
